// File: rtl/rcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcp_pkg;

  // Field and storage widths
  localparam int CYC_W      = 64;
  localparam int CNT_W      = 32;
  localparam int DEPTH_W    = 16;
  localparam int OP_W       = 3;
  localparam int FREG_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Nesting depths that open and close a pair interval
  localparam logic [DEPTH_W-1:0] DEPTH_PAIR_CLOSE = 16'd3;
  localparam logic [DEPTH_W-1:0] DEPTH_PAIR_OPEN  = 16'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_REGION = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_START    = 3'd0,
    OP_START_NC = 3'd1,
    OP_STOP     = 3'd2,
    OP_GET      = 3'd3,
    OP_GET_PAIR = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ELAPSED,
    ST_CYCLES,
    ST_CALLS,
    ST_PAIR_DIFF,
    ST_PAIR_CYCLES,
    ST_PAIR_CALLS,
    ST_FINISH
  } state_t;

  // One row of a counter table: call count and cycle total
  typedef struct packed {
    logic [CNT_W-1:0] calls;
    logic [CYC_W-1:0] cycles;
  } row_t;

endpackage

`default_nettype wire

// File: rtl/rcp_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module rcp_alu
  import rcp_pkg::*;
(
  input  logic [CYC_W-1:0] a,
  input  logic [CYC_W-1:0] b,
  input  logic             sub,
  output logic [CYC_W-1:0] y
);

  // Add or subtract with wrap; subtract as a plus inverted b plus one
  assign y = a + (sub ? ~b : b) + {{(CYC_W-1){1'b0}}, sub};

endmodule

`default_nettype wire

// File: rtl/region_cycle_profiler.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-region cycle profiler. An input word (op, region, column_region,
// timestamp) is taken on in_valid/in_ready; every word gives exactly one
// result word (elapsed, call_count, cycle_total) on out_valid/out_ready.
// Registers are written on cfg_valid/cfg_ready (cfg_ready is always high). The
// user must write them only while no word is in flight; the block does not enforce it.
// One word is processed at a time by a single 64-bit add/subtract unit
// stepped by a small sequencer; in_ready is low while a word is in work.
// Sequencer steps from acceptance up to the finish step, by op:
//   start, get, get pair: read;  unused op or bad index: none
//   start without count: read, calls;  stop: read, elapsed, cycles, calls
//   a pair update adds pair diff, pair cycles, pair calls;  clear all: a
//   clearing pass (one pair-table row per cycle). The result register is
// loaded as finish returns to idle. After reset a clearing pass over all pair
// rows zeroes all tables and start stamps; in_ready stays low until it ends.
// A stalled receiver holds the finished result; the sequencer waits in its
// last step until the result register is free.
module region_cycle_profiler
  import rcp_pkg::*;
#(
  parameter int NUM_REGIONS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         op,
  input  logic [FREG_W-1:0]       region,
  input  logic [FREG_W-1:0]       column_region,
  input  logic [CYC_W-1:0]        timestamp,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CYC_W-1:0]        elapsed,
  output logic signed [CNT_W-1:0] call_count,
  output logic [CYC_W-1:0]        cycle_total
);

  localparam int IDX_W     = $clog2(NUM_REGIONS);
  localparam int PAIR_N    = NUM_REGIONS * NUM_REGIONS;
  localparam int PAIR_W    = $clog2(PAIR_N);
  localparam logic [PAIR_W-1:0] SWEEP_LAST = PAIR_W'(PAIR_N - 1);
  localparam logic [PAIR_W-1:0] SWEEP_ROWS = PAIR_W'(NUM_REGIONS);
  localparam logic [PAIR_W-1:0] PAIR_COLS  = PAIR_W'(NUM_REGIONS);

  // Tables
  logic [CYC_W-1:0] stamp_mem [NUM_REGIONS];
  row_t             row_mem   [NUM_REGIONS];
  row_t             pair_mem  [PAIR_N];

  // Control state
  state_t              state, state_next;
  logic [PAIR_W-1:0]   sweep;
  logic                clr_stamps;
  logic                clr_item;
  logic                pair_mode_enable;
  logic [FREG_W-1:0]   run_region;
  logic [DEPTH_W-1:0]  nest_depth;
  logic [IDX_W-1:0]    prev_region;
  logic [CYC_W-1:0]    prev_stamp;

  // Latched word and working registers
  op_t                 op_q;
  logic [IDX_W-1:0]    region_q;
  logic [IDX_W-1:0]    col_q;
  logic [CYC_W-1:0]    ts_q;
  logic                act_q;
  logic                close_q;
  logic                mark_q;
  logic [CYC_W-1:0]    alu_q;
  logic [CYC_W-1:0]    elapsed_q;
  logic [CYC_W-1:0]    stamp_rd;
  row_t                row_rd;
  row_t                pair_rd;

  // Decode of the incoming word
  op_t                 op_in;
  logic                reg_ok, col_ok, act_in;
  logic                start_in, stop_in, run_hit;
  logic [DEPTH_W-1:0]  depth_step;
  logic                close_in, mark_in;
  logic                in_fire, out_free, finish_go, sweep_row;

  // Shared adder
  logic [CYC_W-1:0]    alu_a, alu_b, alu_y;
  logic                alu_sub;

  // Table ports
  logic                stamp_we, row_we, pair_we;
  logic [IDX_W-1:0]    stamp_waddr, row_waddr;
  logic [CYC_W-1:0]    stamp_wdata;
  row_t                row_wdata, pair_wdata;
  logic [PAIR_W-1:0]   pair_row, pair_col, pair_addr, pair_waddr;

  rcp_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign finish_go = (state == ST_FINISH) && out_free;
  assign sweep_row = (sweep < SWEEP_ROWS);

  // Decode the word at the input
  always_comb begin
    op_in      = op_t'(op);
    reg_ok     = (9'(region) < 9'(NUM_REGIONS));
    col_ok     = (9'(column_region) < 9'(NUM_REGIONS));
    start_in   = ((op_in == OP_START) || (op_in == OP_START_NC)) && reg_ok;
    stop_in    = (op_in == OP_STOP) && reg_ok;
    run_hit    = (region == run_region);
    depth_step = start_in ? nest_depth + DEPTH_W'(1) : nest_depth - DEPTH_W'(1);
    close_in   = pair_mode_enable &&
                 ((start_in && !run_hit && (depth_step == DEPTH_PAIR_CLOSE)) ||
                  (stop_in && run_hit));
    mark_in    = pair_mode_enable &&
                 ((start_in && run_hit) ||
                  (stop_in && !run_hit && (depth_step == DEPTH_PAIR_OPEN)));
    unique case (op_in)
      OP_START, OP_START_NC, OP_STOP, OP_GET: act_in = reg_ok;
      OP_GET_PAIR:                            act_in = reg_ok && col_ok;
      OP_CLEAR:                               act_in = 1'b1;
      default:                                act_in = 1'b0;
    endcase
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and adder operands
  always_comb begin
    state_next = state;
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (sweep == SWEEP_LAST) begin
          state_next = clr_item ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (!act_in) begin
            state_next = ST_FINISH;
          end else if (op_in == OP_CLEAR) begin
            state_next = ST_CLEAR;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        unique case (op_q)
          OP_STOP:     state_next = ST_ELAPSED;
          OP_START_NC: state_next = ST_CALLS;
          OP_START:    state_next = close_q ? ST_PAIR_DIFF : ST_FINISH;
          default:     state_next = ST_FINISH;
        endcase
      end
      ST_ELAPSED: begin
        alu_a      = ts_q;
        alu_b      = stamp_rd;
        alu_sub    = 1'b1;
        state_next = ST_CYCLES;
      end
      ST_CYCLES: begin
        alu_a      = row_rd.cycles;
        alu_b      = alu_q;
        state_next = ST_CALLS;
      end
      ST_CALLS: begin
        alu_a      = {{(CYC_W-CNT_W){1'b0}}, row_rd.calls};
        alu_b      = CYC_W'(1);
        alu_sub    = (op_q == OP_START_NC);
        state_next = close_q ? ST_PAIR_DIFF : ST_FINISH;
      end
      ST_PAIR_DIFF: begin
        alu_a      = ts_q;
        alu_b      = prev_stamp;
        alu_sub    = 1'b1;
        state_next = ST_PAIR_CYCLES;
      end
      ST_PAIR_CYCLES: begin
        alu_a      = pair_rd.cycles;
        alu_b      = alu_q;
        state_next = ST_PAIR_CALLS;
      end
      ST_PAIR_CALLS: begin
        alu_a      = {{(CYC_W-CNT_W){1'b0}}, pair_rd.calls};
        alu_b      = CYC_W'(1);
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Pair entry: row is the previous region, or the queried row on get pair
  always_comb begin
    pair_row  = PAIR_W'((op_q == OP_GET_PAIR) ? region_q : prev_region);
    pair_col  = PAIR_W'((op_q == OP_GET_PAIR) ? col_q : region_q);
    pair_addr = PAIR_W'(pair_row * PAIR_COLS + pair_col);
  end

  // Table write ports
  always_comb begin
    stamp_we    = ((state == ST_CLEAR) && clr_stamps && sweep_row) ||
                  ((state == ST_READ) && ((op_q == OP_START) || (op_q == OP_START_NC)));
    stamp_waddr = (state == ST_CLEAR) ? sweep[IDX_W-1:0] : region_q;
    stamp_wdata = (state == ST_CLEAR) ? '0 : ts_q;

    row_we           = ((state == ST_CLEAR) && sweep_row) || (state == ST_CALLS);
    row_waddr        = (state == ST_CLEAR) ? sweep[IDX_W-1:0] : region_q;
    row_wdata.calls  = alu_y[CNT_W-1:0];
    row_wdata.cycles = (op_q == OP_STOP) ? alu_q : row_rd.cycles;
    if (state == ST_CLEAR) begin
      row_wdata = '0;
    end

    pair_we           = (state == ST_CLEAR) || (state == ST_PAIR_CALLS);
    pair_waddr        = (state == ST_CLEAR) ? sweep : pair_addr;
    pair_wdata.calls  = alu_y[CNT_W-1:0];
    pair_wdata.cycles = alu_q;
    if (state == ST_CLEAR) begin
      pair_wdata = '0;
    end
  end

  // Tables: one write and one registered read each
  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= stamp_wdata;
    end
    if (state == ST_READ) begin
      stamp_rd <= stamp_mem[region_q];
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (state == ST_READ) begin
      row_rd <= row_mem[region_q];
    end
  end

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[pair_waddr] <= pair_wdata;
    end
    if (state == ST_READ) begin
      pair_rd <= pair_mem[pair_addr];
    end
  end

  // Control registers: config, sweep, nesting, result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep            <= '0;
      clr_stamps       <= 1'b1;
      clr_item         <= 1'b0;
      pair_mode_enable <= 1'b0;
      run_region       <= '0;
      nest_depth       <= '0;
      prev_region      <= '0;
      prev_stamp       <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PAIR_MODE:  pair_mode_enable <= cfg_data[0];
          CFG_RUN_REGION: run_region       <= cfg_data[FREG_W-1:0];
          default:        ;
        endcase
      end

      // Advance the clearing pass; arm it on clear all
      if (state == ST_CLEAR) begin
        sweep <= (sweep == SWEEP_LAST) ? '0 : sweep + PAIR_W'(1);
      end
      if (in_fire && act_in && (op_in == OP_CLEAR)) begin
        sweep      <= '0;
        clr_stamps <= 1'b0;
        clr_item   <= 1'b1;
      end

      if (in_fire && pair_mode_enable && (start_in || stop_in)) begin
        nest_depth <= depth_step;
      end

      // Mark the depth-2 boundary, or a start of the run region, once the word is done
      if (finish_go && mark_q) begin
        prev_region <= region_q;
        prev_stamp  <= ts_q;
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (finish_go) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Latch the word, step the adder, load the result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q     <= op_in;
      region_q <= IDX_W'(region);
      col_q    <= IDX_W'(column_region);
      ts_q     <= timestamp;
      act_q    <= act_in;
      close_q  <= close_in;
      mark_q   <= mark_in;
    end
    if ((state == ST_ELAPSED) || (state == ST_CYCLES) ||
        (state == ST_PAIR_DIFF) || (state == ST_PAIR_CYCLES)) begin
      alu_q <= alu_y;
    end
    if (state == ST_ELAPSED) begin
      elapsed_q <= alu_y;
    end
    if (finish_go) begin
      elapsed     <= '0;
      call_count  <= '0;
      cycle_total <= '0;
      if (act_q) begin
        unique case (op_q)
          OP_STOP: elapsed <= elapsed_q;
          OP_GET: begin
            call_count  <= row_rd.calls;
            cycle_total <= row_rd.cycles;
          end
          OP_GET_PAIR: begin
            call_count  <= pair_rd.calls;
            cycle_total <= pair_rd.cycles;
          end
          default: ;
        endcase
      end
    end
  end

  // One word at a time: the input closes right after a word is taken
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input accepted again while a word is in work");

  // Pair table changes only on a clearing pass or in pair mode
  assert property (@(posedge clk) disable iff (rst)
    pair_we |-> ((state == ST_CLEAR) || pair_mode_enable))
    else $error("pair table written with pair mode off");

  // A stop raises the region count by exactly one
  assert property (@(posedge clk) disable iff (rst)
    ((state == ST_CALLS) && (op_q == OP_STOP)) |->
      (row_wdata.calls == CNT_W'(row_rd.calls + CNT_W'(1))))
    else $error("stop did not raise the call count by one");

  // Nesting depth holds while pair mode is off
  assert property (@(posedge clk) disable iff (rst)
    !pair_mode_enable |=> $stable(nest_depth))
    else $error("nesting depth moved with pair mode off");

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import rcp_pkg::*;

  localparam int NUM_ROWS = 64;
  localparam int PAIR_ROWS = NUM_ROWS * NUM_ROWS;
  localparam int WORDS_PER_PHASE = 240;
  localparam int NUM_PHASES = 8;
  localparam int HOLD_CYCLES = 400;

  // Opcodes the block treats as no-ops, and a register index it ignores
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [CYC_W-1:0]        elapsed;
    logic signed [CNT_W-1:0] calls;
    logic [CYC_W-1:0]        total;
  } result_word_t;

  // Track counter tables and predict the result word of every accepted input word
  class profile_tracker;
    logic [CYC_W-1:0]   start_stamp [NUM_ROWS];
    logic [CYC_W-1:0]   row_cycles [NUM_ROWS];
    logic [CNT_W-1:0]   row_calls [NUM_ROWS];
    logic [CYC_W-1:0]   pair_cycles [PAIR_ROWS];
    logic [CNT_W-1:0]   pair_calls [PAIR_ROWS];
    logic               pair_on;
    logic [FREG_W-1:0]  run_row;
    logic [DEPTH_W-1:0] depth;
    logic [FREG_W-1:0]  prev_row;
    logic [CYC_W-1:0]   prev_stamp;
    result_word_t       pending[$];
    int errors;
    int words_in;
    int words_out;
    int pair_hits;
    int clears;

    function void power_on();
      foreach (start_stamp[i]) start_stamp[i] = '0;
      wipe_totals();
      pair_on = 1'b0;
      run_row = '0;
      depth = '0;
      prev_row = '0;
      prev_stamp = '0;
      errors = 0;
      words_in = 0;
      words_out = 0;
      pair_hits = 0;
      clears = 0;
    endfunction

    function void wipe_totals();
      foreach (row_cycles[i]) begin
        row_cycles[i] = '0;
        row_calls[i] = '0;
      end
      foreach (pair_cycles[i]) begin
        pair_cycles[i] = '0;
        pair_calls[i] = '0;
      end
    endfunction

    function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PAIR_MODE: pair_on = data[0];
        CFG_RUN_REGION: run_row = data[FREG_W-1:0];
        default: ;
      endcase
    endfunction

    function void close_pair(logic [FREG_W-1:0] row, logic [CYC_W-1:0] ts);
      logic [2*FREG_W-1:0] idx;
      idx = {prev_row, row};
      pair_calls[idx] = pair_calls[idx] + 1;
      pair_cycles[idx] = pair_cycles[idx] + (ts - prev_stamp);
      pair_hits++;
    endfunction

    function void note_word(logic [OP_W-1:0] op_code, logic [FREG_W-1:0] row,
                            logic [FREG_W-1:0] col, logic [CYC_W-1:0] ts);
      result_word_t want;
      want.elapsed = '0;
      want.calls = '0;
      want.total = '0;
      words_in++;
      case (op_code)
        OP_START, OP_START_NC: begin
          start_stamp[row] = ts;
          if (op_code == OP_START_NC) row_calls[row] = row_calls[row] - 1;
          if (pair_on) begin
            depth = depth + DEPTH_W'(1);
            if (row == run_row) begin
              prev_row = row;
              prev_stamp = ts;
            end else if (depth == DEPTH_PAIR_CLOSE) begin
              close_pair(row, ts);
            end
          end
        end
        OP_STOP: begin
          want.elapsed = ts - start_stamp[row];
          row_cycles[row] = row_cycles[row] + want.elapsed;
          row_calls[row] = row_calls[row] + 1;
          if (pair_on) begin
            depth = depth - DEPTH_W'(1);
            if (row == run_row) begin
              close_pair(row, ts);
            end else if (depth == DEPTH_PAIR_OPEN) begin
              prev_row = row;
              prev_stamp = ts;
            end
          end
        end
        OP_GET: begin
          want.calls = row_calls[row];
          want.total = row_cycles[row];
        end
        OP_GET_PAIR: begin
          want.calls = pair_calls[{row, col}];
          want.total = pair_cycles[{row, col}];
        end
        OP_CLEAR: begin
          wipe_totals();
          clears++;
        end
        default: ;
      endcase
      pending.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_word(logic [CYC_W-1:0] got_elapsed, logic signed [CNT_W-1:0] got_calls,
                    logic [CYC_W-1:0] got_total);
      result_word_t want;
      words_out++;
      if (pending.size() == 0) begin
        report($sformatf("result word %0d arrived with no input word pending", words_out));
        return;
      end
      want = pending.pop_front();
      if (got_elapsed !== want.elapsed)
        report($sformatf("word %0d elapsed %0h, want %0h", words_out, got_elapsed,
                         want.elapsed));
      if (got_calls !== want.calls)
        report($sformatf("word %0d call_count %0d, want %0d", words_out, got_calls,
                         want.calls));
      if (got_total !== want.total)
        report($sformatf("word %0d cycle_total %0h, want %0h", words_out, got_total,
                         want.total));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_PAIR_MODE;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         op = OP_GET;
  logic [FREG_W-1:0]       region = '0;
  logic [FREG_W-1:0]       column_region = '0;
  logic [CYC_W-1:0]        timestamp = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [CYC_W-1:0]        elapsed;
  logic signed [CNT_W-1:0] call_count;
  logic [CYC_W-1:0]        cycle_total;

  profile_tracker tracker;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic [CYC_W-1:0] now_ts;
  logic [FREG_W-1:0] open_rows[$];

  region_cycle_profiler #(
    .NUM_REGIONS(NUM_ROWS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .region(region),
    .column_region(column_region),
    .timestamp(timestamp),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .elapsed(elapsed),
    .call_count(call_count),
    .cycle_total(cycle_total)
  );

  always #4 clk = ~clk;

  // Drive receiver ready: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Check every result word taken by the receiver
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_word(elapsed, call_count, cycle_total);
  end

  // Write one register; valid stays up for the caller to drop
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_config(idx, data);
  endtask

  // Offer one input word after a random gap; hold it until accepted
  task automatic send_word(logic [OP_W-1:0] w_op, logic [FREG_W-1:0] w_row,
                           logic [FREG_W-1:0] w_col, logic [CYC_W-1:0] w_ts);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= w_op;
    region <= w_row;
    column_region <= w_col;
    timestamp <= w_ts;
    do @(posedge clk); while (!in_ready);
    tracker.note_word(w_op, w_row, w_col, w_ts);
  endtask

  // Favor a few rows so pairs and totals get revisited
  function automatic logic [FREG_W-1:0] pick_row();
    return FREG_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 7)
                                               : $urandom_range(0, NUM_ROWS - 1));
  endfunction

  // Build one word: mostly nested start/stop with queries, some noise
  task automatic random_word();
    int pick;
    int lvl;
    logic [OP_W-1:0]   w_op;
    logic [FREG_W-1:0] w_row;
    logic [FREG_W-1:0] w_col;
    logic [CYC_W-1:0]  w_ts;
    pick = $urandom_range(0, 99);
    lvl = tracker.pair_on ? int'($signed(tracker.depth)) : open_rows.size();
    now_ts = now_ts + $urandom_range(1, 3000);
    if ($urandom_range(0, 199) == 0) now_ts = now_ts + {$urandom, $urandom};
    w_row = FREG_W'($urandom_range(0, NUM_ROWS - 1));
    w_col = FREG_W'($urandom_range(0, NUM_ROWS - 1));
    w_ts = now_ts;
    if (pick < 8) begin
      w_op = OP_W'($urandom_range(0, 7));
      w_ts = {$urandom, $urandom};
    end else if (pick < 9) begin
      w_op = OP_CLEAR;
    end else if (pick < 20) begin
      w_op = OP_GET;
      if (pick < 17) w_row = pick_row();
    end else if (pick < 30) begin
      w_op = OP_GET_PAIR;
      w_row = ($urandom_range(0, 2) == 0) ? tracker.run_row : pick_row();
      w_col = pick_row();
    end else if (lvl <= 0 || (lvl < 5 && $urandom_range(0, 1) == 0)) begin
      w_op = ($urandom_range(0, 4) == 0) ? OP_START_NC : OP_START;
      w_row = (lvl <= 0 && $urandom_range(0, 9) < 7) ? tracker.run_row : pick_row();
      open_rows.push_back(w_row);
      if (open_rows.size() > 8) void'(open_rows.pop_front());
    end else begin
      w_op = OP_STOP;
      if (open_rows.size() != 0) w_row = open_rows.pop_back();
    end
    send_word(w_op, w_row, w_col, w_ts);
  endtask

  // Drop valid and wait until every result is back and the block takes words again
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int phase;
    int k;
    logic [CFG_DATA_W-1:0] mode_data;
    logic [CFG_DATA_W-1:0] run_data;
    tracker = new;
    tracker.power_on();
    now_ts = {$urandom, $urandom};

    // Hold reset, then wait out the clearing pass
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (!in_ready);

    // Directed words: pair mode on, outermost region at the top index
    write_reg(CFG_PAIR_MODE, 8'h01);
    write_reg(CFG_RUN_REGION, 8'd63);
    cfg_valid <= 1'b0;
    send_word(OP_GET, 0, 0, '0);
    send_word(OP_START, 1, 0, 64'd100);
    send_word(OP_START, 2, 0, 64'd150);
    // depth three before any mark closes a pair from row zero, stamp zero
    send_word(OP_START, 3, 0, 64'd200);
    send_word(OP_GET_PAIR, 0, 3, '0);
    send_word(OP_STOP, 3, 0, 64'd260);
    send_word(OP_START_NC, 4, 0, 64'd300);
    send_word(OP_GET_PAIR, 3, 4, '0);
    send_word(OP_STOP, 4, 0, '1);
    send_word(OP_STOP, 2, 0, '0);
    send_word(OP_STOP, 1, 0, 64'd500);
    // stop without a start wraps the depth below zero
    send_word(OP_STOP, 1, 0, 64'd600);
    send_word(OP_START, 63, 63, '1);
    send_word(OP_STOP, 63, 63, 64'd5);
    send_word(OP_GET, 63, 0, '0);
    send_word(OP_GET_PAIR, 63, 63, '0);
    send_word(OP_GET, 4, 0, '0);
    send_word(OP_GET, 1, 0, '0);
    send_word(OP_UNUSED_LO, 5, 9, 64'd123);
    send_word(OP_UNUSED_HI, '1, '1, '1);
    send_word(OP_CLEAR, '1, '1, {$urandom, $urandom});
    send_word(OP_GET_PAIR, 63, 63, '0);
    send_word(OP_GET, 2, 0, '0);
    send_word(OP_START, 0, 0, '0);
    drain();

    // Random phases: each with its own settings and idling mix
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 69; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 69; end
        default: begin idle_pct = 28; stall_pct <= 28; end
      endcase
      mode_data = CFG_DATA_W'($urandom);
      mode_data[0] = (phase == 2 || phase == 4) ? 1'b0 :
                     (phase == 7) ? 1'($urandom_range(0, 1)) : 1'b1;
      run_data = CFG_DATA_W'($urandom);
      case (phase)
        0, 2: run_data[FREG_W-1:0] = '0;
        1, 4: run_data[FREG_W-1:0] = '1;
        6: run_data[FREG_W-1:0] = FREG_W'($urandom_range(0, 7));
        default: ;
      endcase
      write_reg(CFG_PAIR_MODE, mode_data);
      write_reg(CFG_RUN_REGION, run_data);
      if (phase == 3) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
      cfg_valid <= 1'b0;
      open_rows.delete();
      // stall the receiver long enough to back the block up
      if (phase == 1) hold_req <= hold_req + 1;
      for (k = 0; k < WORDS_PER_PHASE; k++) random_word();
      drain();
    end

    // Let any stray result show up, then close out
    repeat (16) @(posedge clk);
    if (tracker.pending.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending.size()));
    $display("Summary: %0d input words, %0d results checked across %0d setting phases",
             tracker.words_in, tracker.words_out, NUM_PHASES + 1);
    $display("  pair intervals closed: %0d, clear-all words: %0d, mismatches: %0d",
             tracker.pair_hits, tracker.clears, tracker.errors);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
